>>> sv/ir_proximity_ambient_cancel_sequencer_core_assert.svh
// assertion macros for the ir proximity ambient cancel sequencer
`ifndef IR_PROXIMITY_AMBIENT_CANCEL_SEQUENCER_CORE_ASSERT_SVH
`define IR_PROXIMITY_AMBIENT_CANCEL_SEQUENCER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define IPAC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IPAC_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IPAC_ASSERT(name, clk, rst, prop, msg)
`define IPAC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

>>> sv/ipac_pkg.sv
// shared types and constants for the ir proximity ambient cancel sequencer
`timescale 1ns / 1ps
package ipac_pkg;

   localparam int CYCLE_LEN_DEFAULT = 80;
   localparam int CHANNELS_DEFAULT  = 8;

   localparam logic [11:0] ADC_FULL        = 12'd4095;
   localparam int          NOISE_LIMIT     = 2000;
   localparam logic [11:0] AMB_OFF_RESET   = 12'd30;
   localparam logic [11:0] REFL_OFF_RESET  = 12'd5;
   localparam logic [11:0] NOISE_OFF_RESET = 12'd15;

   typedef enum logic [1:0] {
      OP_TICK   = 2'd0,
      OP_SAMPLE = 2'd1,
      OP_READ   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_PASSIVE = 2'd0,
      MODE_PULSE   = 2'd1,
      MODE_EMIT    = 2'd2,
      MODE_NOISE   = 2'd3
   } sense_type;

   typedef enum logic [1:0] {
      ARM_NONE    = 2'd0,
      ARM_AMBIENT = 2'd1,
      ARM_MIXED   = 2'd2
   } arm_type;

   typedef enum logic [1:0] {
      RD_AMBIENT    = 2'd0,
      RD_REFLECTION = 2'd1,
      RD_NOISE      = 2'd2
   } read_kind_type;

   typedef enum logic [2:0] {
      CSR_ENABLE      = 3'd0,
      CSR_SENSE_MODE  = 3'd1,
      CSR_AMB_OFFSET  = 3'd2,
      CSR_REFL_OFFSET = 3'd3,
      CSR_NOISE_OFFSET = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  channel;
      logic [11:0] sample;
      logic [1:0]  read_kind;
   } req_type;

   typedef struct packed {
      logic        emitter_on;
      logic [1:0]  capture_armed;
      logic        cycle_trigger;
      logic [11:0] read_value;
      logic [15:0] cycle_count;
   } rsp_type;

   // decoded item handed from front to back
   typedef struct packed {
      op_type      op;
      logic [2:0]  idx;
      logic        store_ok;
      logic        last_ch;
      logic [11:0] value;
      logic [1:0]  read_kind;
   } cmd_type;

   typedef struct packed {
      logic        enable;
      sense_type   sensing_mode;
      logic [11:0] ambient_offset;
      logic [11:0] reflection_offset;
      logic [11:0] noise_offset;
   } cfg_type;

endpackage

>>> sv/ipac_queue.sv
// two-entry queue between pipeline parts
`timescale 1ns / 1ps
module ipac_queue #(
   parameter type entry_type = logic
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/ipac_front.sv
// front part: classifies incoming items into commands for the back part
`timescale 1ns / 1ps
module ipac_front #(
   parameter int CHANNELS = ipac_pkg::CHANNELS_DEFAULT
) (
   input  ipac_pkg::req_type req,
   output ipac_pkg::cmd_type cmd
);

   logic [4:0] ch_ext;
   logic [4:0] rem;

   assign ch_ext = {2'b00, req.channel};

   // channel modulo the store depth, by repeated subtraction
   always_comb begin
      rem = ch_ext;
      for (int k = 0; k < 8; k++) begin
         if (rem >= 5'(CHANNELS)) begin
            rem = rem - 5'(CHANNELS);
         end
      end
   end

   always_comb begin
      cmd.op        = ipac_pkg::op_type'(req.mode);
      cmd.idx       = rem[2:0];
      cmd.store_ok  = (ch_ext < 5'(CHANNELS));
      cmd.last_ch   = ((ch_ext + 5'd1) >= 5'(CHANNELS));
      cmd.value     = ipac_pkg::ADC_FULL - req.sample;
      cmd.read_kind = req.read_kind;
   end

endmodule

>>> sv/ipac_back.sv
// back part: sequencer state, light stores and read arithmetic
`timescale 1ns / 1ps
`include "ir_proximity_ambient_cancel_sequencer_core_assert.svh"
module ipac_back #(
   parameter int CYCLE_LEN = ipac_pkg::CYCLE_LEN_DEFAULT,
   parameter int CHANNELS  = ipac_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  ipac_pkg::cfg_type cfg,
   input  ipac_pkg::cmd_type cmd,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  logic              rsp_full,
   output logic              rsp_push,
   output ipac_pkg::rsp_type rsp
);

   localparam int PhaseW  = $clog2(CYCLE_LEN);
   localparam int ChIdxW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   logic [PhaseW-1:0] phase_ff;
   logic [PhaseW-1:0] phase_in;
   logic [15:0]       cycles_ff;
   logic [15:0]       cycles_in;
   logic              emitter_ff;
   logic              emitter_in;
   ipac_pkg::arm_type armed_ff;
   ipac_pkg::arm_type armed_in;
   logic              was_en_ff;
   logic [11:0]       amb_ff [CHANNELS];
   logic [11:0]       mix_ff [CHANNELS];

   logic              exec;
   logic              rise;
   logic              fall;
   logic [PhaseW-1:0] ph0;
   logic              em0;
   ipac_pkg::arm_type arm0;
   logic [4:0]        idx_ext;
   logic [ChIdxW-1:0] idx;
   logic [11:0]       amb_rd;
   logic [11:0]       mix_rd;
   logic signed [14:0] amb_d;
   logic signed [14:0] refl_d;
   logic signed [14:0] noise_d;
   logic              trig;
   logic [11:0]       read_val;
   logic              amb_we;
   logic              mix_we;
   logic              emit_mode;

   function automatic logic [11:0] clamp12(input logic signed [14:0] v);
      logic [11:0] r;
      if (v < 15'sd0) begin
         r = 12'd0;
      end else if (v > $signed({3'b000, ipac_pkg::ADC_FULL})) begin
         r = ipac_pkg::ADC_FULL;
      end else begin
         r = v[11:0];
      end
      return r;
   endfunction

   assign exec     = !cmd_empty && !rsp_full;
   assign cmd_pop  = exec;
   assign rsp_push = exec;

   // enable edges are seen at the start of each item
   assign rise      = cfg.enable && !was_en_ff;
   assign fall      = !cfg.enable && was_en_ff;
   assign emit_mode = (cfg.sensing_mode == ipac_pkg::MODE_EMIT);
   assign ph0       = (rise || fall) ? '0 : phase_ff;
   assign em0       = fall ? 1'b0 : ((rise && emit_mode) ? 1'b1 : emitter_ff);
   assign arm0      = fall ? ipac_pkg::ARM_NONE : armed_ff;

   assign idx_ext = {2'b00, cmd.idx};
   assign idx     = idx_ext[ChIdxW-1:0];
   assign amb_rd  = fall ? 12'd0 : amb_ff[idx];
   assign mix_rd  = fall ? 12'd0 : mix_ff[idx];

   assign amb_d   = $signed({3'b000, amb_rd}) - $signed({3'b000, cfg.ambient_offset});
   assign refl_d  = $signed({3'b000, mix_rd}) - $signed({3'b000, amb_rd})
                    - $signed({3'b000, cfg.reflection_offset});
   assign noise_d = 15'sd0 - $signed({3'b000, cfg.noise_offset}) - refl_d;

   always_comb begin
      phase_in   = ph0;
      emitter_in = em0;
      armed_in   = arm0;
      cycles_in  = cycles_ff;
      trig       = 1'b0;
      read_val   = 12'd0;
      amb_we     = 1'b0;
      mix_we     = 1'b0;
      case (cmd.op)
         ipac_pkg::OP_TICK: begin
            if (cfg.enable) begin
               if (ph0 < PhaseW'(4) && cfg.sensing_mode != ipac_pkg::MODE_NOISE) begin
                  case (ph0[1:0])
                     2'd0: begin
                        armed_in = emit_mode ? ipac_pkg::ARM_MIXED : ipac_pkg::ARM_AMBIENT;
                     end
                     2'd1: begin
                        emitter_in = !emit_mode;
                     end
                     2'd2: begin
                        armed_in = emit_mode ? ipac_pkg::ARM_AMBIENT : ipac_pkg::ARM_MIXED;
                     end
                     default: begin
                        cycles_in = cycles_ff + 16'd1;
                        trig      = 1'b1;
                     end
                  endcase
               end
               phase_in = (ph0 == PhaseW'(CYCLE_LEN - 1)) ? '0 : ph0 + PhaseW'(1);
            end
         end
         ipac_pkg::OP_SAMPLE: begin
            if (arm0 != ipac_pkg::ARM_NONE) begin
               if (cmd.store_ok) begin
                  amb_we = (arm0 == ipac_pkg::ARM_AMBIENT);
                  mix_we = (arm0 != ipac_pkg::ARM_AMBIENT);
               end
               // last channel closes the capture
               if (cmd.last_ch) begin
                  if (emit_mode) begin
                     if (arm0 == ipac_pkg::ARM_AMBIENT) begin
                        emitter_in = 1'b1;
                     end
                  end else if (cfg.sensing_mode != ipac_pkg::MODE_NOISE) begin
                     if (arm0 == ipac_pkg::ARM_MIXED) begin
                        emitter_in = 1'b0;
                     end
                  end
                  armed_in = ipac_pkg::ARM_NONE;
               end
            end
         end
         ipac_pkg::OP_READ: begin
            case (cmd.read_kind)
               ipac_pkg::RD_AMBIENT:    read_val = clamp12(amb_d);
               ipac_pkg::RD_REFLECTION: read_val = clamp12(refl_d);
               ipac_pkg::RD_NOISE: begin
                  read_val = (refl_d > 15'(ipac_pkg::NOISE_LIMIT)) ? 12'd0 : clamp12(noise_d);
               end
               default: read_val = 12'd0;
            endcase
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.emitter_on    = emitter_in;
      rsp.capture_armed = armed_in;
      rsp.cycle_trigger = trig;
      rsp.read_value    = read_val;
      rsp.cycle_count   = cycles_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= '0;
         cycles_ff  <= 16'd0;
         emitter_ff <= 1'b0;
         armed_ff   <= ipac_pkg::ARM_NONE;
         was_en_ff  <= 1'b0;
      end else if (exec) begin
         phase_ff   <= phase_in;
         cycles_ff  <= cycles_in;
         emitter_ff <= emitter_in;
         armed_ff   <= armed_in;
         was_en_ff  <= cfg.enable;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (exec && fall)) begin
         for (int k = 0; k < CHANNELS; k++) begin
            amb_ff[k] <= 12'd0;
            mix_ff[k] <= 12'd0;
         end
      end else if (exec) begin
         if (amb_we) begin
            amb_ff[idx] <= cmd.value;
         end
         if (mix_we) begin
            mix_ff[idx] <= cmd.value;
         end
      end
   end

   `IPAC_ASSERT(trig_at_phase_three, clock, reset, exec && trig |-> cfg.enable && ph0 == PhaseW'(3), "cycle trigger outside phase three")
   `IPAC_ASSERT(count_only_on_trig, clock, reset, !(exec && trig) |=> $stable(cycles_ff), "cycle count moved without a trigger")
   `IPAC_ASSERT(fall_quiets_emitter, clock, reset, exec && fall |=> !emitter_ff && armed_ff == ipac_pkg::ARM_NONE, "disable left emitter or capture active")
   `IPAC_ASSERT_ALWAYS(reset_state_clear, clock, reset |=> !emitter_ff && cycles_ff == 16'd0 && phase_ff == '0, "state not cleared by reset")

endmodule

>>> sv/ir_proximity_ambient_cancel_sequencer_core.sv
// top level of the ir proximity ambient cancel sequencer
//
//   channel   ports                                      transfer when
//   request   push, full, req_data                       push && !full
//   response  pop, empty, rsp_data                       pop && !empty
//   config    csr_valid, csr_ready, csr_index, csr_wdata csr_valid && csr_ready
//
// one item per cycle sustained while the response queue is not full; an item reaches
// the response queue through a two-entry command queue and the single back stage
// back stage stalls only when the two-entry response queue is full; full then follows
// synchronous active-high reset clears queues, sequencer state and both light stores
// csr_ready is always high
`timescale 1ns / 1ps
module ir_proximity_ambient_cancel_sequencer_core #(
   parameter int CYCLE_LEN = ipac_pkg::CYCLE_LEN_DEFAULT,
   parameter int CHANNELS  = ipac_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  ipac_pkg::req_type req_data,
   input  logic              pop,
   output logic              empty,
   output ipac_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_wdata
);

   ipac_pkg::cfg_type cfg_ff;
   ipac_pkg::cfg_type cfg_in;
   ipac_pkg::cmd_type front_cmd;
   ipac_pkg::cmd_type back_cmd;
   ipac_pkg::rsp_type back_rsp;
   logic              cmd_empty;
   logic              cmd_pop;
   logic              rsp_full;
   logic              rsp_push;
   logic              csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (ipac_pkg::csr_index_type'(csr_index))
            ipac_pkg::CSR_ENABLE:       cfg_in.enable            = csr_wdata[0];
            ipac_pkg::CSR_SENSE_MODE:
               cfg_in.sensing_mode = ipac_pkg::sense_type'(csr_wdata[1:0]);
            ipac_pkg::CSR_AMB_OFFSET:   cfg_in.ambient_offset    = csr_wdata;
            ipac_pkg::CSR_REFL_OFFSET:  cfg_in.reflection_offset = csr_wdata;
            ipac_pkg::CSR_NOISE_OFFSET: cfg_in.noise_offset      = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable            <= 1'b0;
         cfg_ff.sensing_mode      <= ipac_pkg::MODE_PULSE;
         cfg_ff.ambient_offset    <= ipac_pkg::AMB_OFF_RESET;
         cfg_ff.reflection_offset <= ipac_pkg::REFL_OFF_RESET;
         cfg_ff.noise_offset      <= ipac_pkg::NOISE_OFF_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ipac_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   ipac_queue #(
      .entry_type (ipac_pkg::cmd_type)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (full),
      .pop       (cmd_pop),
      .pop_data  (back_cmd),
      .empty     (cmd_empty)
   );

   ipac_back #(
      .CYCLE_LEN (CYCLE_LEN),
      .CHANNELS  (CHANNELS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (back_cmd),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp       (back_rsp)
   );

   ipac_queue #(
      .entry_type (ipac_pkg::rsp_type)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_data),
      .empty     (empty)
   );

endmodule

>>> tb/ipac_readout_check.sv
// channel monitor, sequencer prediction and result comparison for the ipac core
`timescale 1ns / 1ps
module ipac_readout_check #(
   parameter int CYCLE_LEN = ipac_pkg::CYCLE_LEN_DEFAULT,
   parameter int CHANNELS  = ipac_pkg::CHANNELS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic              full,
   input  ipac_pkg::req_type req_data,
   input  logic              pop,
   input  logic              empty,
   input  ipac_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [11:0]       csr_wdata,
   output int                fail_count,
   output int                pending_count,
   output int                checked_count,
   output int                trigger_count
);
   import ipac_pkg::*;

   // own copy of the register file and sequencer state
   cfg_type     regs;
   logic [6:0]  phase;
   logic [15:0] cycles;
   logic        emitter;
   arm_type     armed;
   logic        was_on;
   logic [11:0] amb_store [CHANNELS];
   logic [11:0] mix_store [CHANNELS];

   rsp_type predicted_status_q [$];
   int      errors;
   int      compared;
   int      triggers;

   task automatic flag_mismatch(string what, int got, int want);
      errors++;
      if (errors <= 40)
         $display("mismatch on %s at result %0d: got %0d, expected %0d",
                  what, compared, got, want);
   endtask

   function automatic void clear_stores();
      for (int k = 0; k < CHANNELS; k++) begin
         amb_store[k] = '0;
         mix_store[k] = '0;
      end
   endfunction

   function automatic logic [11:0] clamp_adc(int v);
      if (v < 0) return '0;
      if (v > int'(ADC_FULL)) return ADC_FULL;
      return 12'(v);
   endfunction

   function automatic void write_register(logic [2:0] idx, logic [11:0] val);
      case (csr_index_type'(idx))
         CSR_ENABLE:       regs.enable = val[0];
         CSR_SENSE_MODE:   regs.sensing_mode = sense_type'(val[1:0]);
         CSR_AMB_OFFSET:   regs.ambient_offset = val;
         CSR_REFL_OFFSET:  regs.reflection_offset = val;
         CSR_NOISE_OFFSET: regs.noise_offset = val;
         default: ;
      endcase
   endfunction

   // one item through the sequencer: returns the status it reports
   function automatic rsp_type advance_sequencer(req_type it);
      rsp_type st;
      logic    emit;
      int      slot;
      int      amb;
      int      mix;
      int      diff;
      st = '0;
      emit = (regs.sensing_mode == MODE_EMIT);

      if (regs.enable && !was_on) begin
         phase = '0;
         if (emit) emitter = 1'b1;
      end else if (!regs.enable && was_on) begin
         phase = '0;
         emitter = 1'b0;
         armed = ARM_NONE;
         clear_stores();
      end
      was_on = regs.enable;

      case (op_type'(it.mode))
         OP_TICK: begin
            if (regs.enable) begin
               if (phase < 7'd4 && regs.sensing_mode != MODE_NOISE) begin
                  case (phase[1:0])
                     2'd0: armed = emit ? ARM_MIXED : ARM_AMBIENT;
                     2'd1: emitter = !emit;
                     2'd2: armed = emit ? ARM_AMBIENT : ARM_MIXED;
                     default: begin
                        cycles = cycles + 16'd1;
                        st.cycle_trigger = 1'b1;
                     end
                  endcase
               end
               if (int'(phase) >= CYCLE_LEN - 1) phase = '0;
               else phase = phase + 7'd1;
            end
         end
         OP_SAMPLE: begin
            if (armed != ARM_NONE) begin
               if (int'(it.channel) < CHANNELS) begin
                  if (armed == ARM_AMBIENT) amb_store[it.channel] = ADC_FULL - it.sample;
                  else mix_store[it.channel] = ADC_FULL - it.sample;
               end
               // last channel closes the capture
               if (int'(it.channel) + 1 >= CHANNELS) begin
                  if (emit) begin
                     if (armed == ARM_AMBIENT) emitter = 1'b1;
                  end else if (regs.sensing_mode != MODE_NOISE) begin
                     if (armed == ARM_MIXED) emitter = 1'b0;
                  end
                  armed = ARM_NONE;
               end
            end
         end
         OP_READ: begin
            slot = int'(it.channel) % CHANNELS;
            amb = int'(amb_store[slot]);
            mix = int'(mix_store[slot]);
            diff = mix - amb - int'(regs.reflection_offset);
            case (read_kind_type'(it.read_kind))
               RD_AMBIENT:    st.read_value = clamp_adc(amb - int'(regs.ambient_offset));
               RD_REFLECTION: st.read_value = clamp_adc(diff);
               RD_NOISE: begin
                  if (diff > NOISE_LIMIT) st.read_value = '0;
                  else st.read_value = clamp_adc(0 - int'(regs.noise_offset) - diff);
               end
               default: st.read_value = '0;
            endcase
         end
         default: ;
      endcase

      st.emitter_on = emitter;
      st.capture_armed = armed;
      st.cycle_count = cycles;
      return st;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         regs.enable = 1'b0;
         regs.sensing_mode = MODE_PULSE;
         regs.ambient_offset = AMB_OFF_RESET;
         regs.reflection_offset = REFL_OFF_RESET;
         regs.noise_offset = NOISE_OFF_RESET;
         phase = '0;
         cycles = '0;
         emitter = 1'b0;
         armed = ARM_NONE;
         was_on = 1'b0;
         clear_stores();
         predicted_status_q.delete();
      end else begin
         // results first, so an item taken this edge is not matched against itself
         if (pop && !empty) begin
            compared++;
            if (predicted_status_q.size() == 0) begin
               flag_mismatch("unexpected result", rsp_data, 0);
            end else begin
               want = predicted_status_q.pop_front();
               if (rsp_data.cycle_trigger === 1'b1) triggers++;
               if (rsp_data.emitter_on !== want.emitter_on)
                  flag_mismatch("emitter_on", rsp_data.emitter_on, want.emitter_on);
               if (rsp_data.capture_armed !== want.capture_armed)
                  flag_mismatch("capture_armed", rsp_data.capture_armed, want.capture_armed);
               if (rsp_data.cycle_trigger !== want.cycle_trigger)
                  flag_mismatch("cycle_trigger", rsp_data.cycle_trigger, want.cycle_trigger);
               if (rsp_data.read_value !== want.read_value)
                  flag_mismatch("read_value", rsp_data.read_value, want.read_value);
               if (rsp_data.cycle_count !== want.cycle_count)
                  flag_mismatch("cycle_count", rsp_data.cycle_count, want.cycle_count);
            end
         end
         if (csr_valid && csr_ready) write_register(csr_index, csr_wdata);
         if (push && !full) predicted_status_q.push_back(advance_sequencer(req_data));
      end
      fail_count    <= errors;
      pending_count <= predicted_status_q.size();
      checked_count <= compared;
      trigger_count <= triggers;
   end

endmodule

>>> tb/tb_ir_proximity_ambient_cancel_sequencer_core.sv
// stimulus, idling and verdict for the ir proximity ambient cancel sequencer core
`timescale 1ns / 1ps
module tb_ir_proximity_ambient_cancel_sequencer_core;
   import ipac_pkg::*;

   localparam int DIRECTED_ITEMS = 27;
   localparam int RANDOM_ITEMS   = 700;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 4;
   localparam int IDLE_LIMIT     = 4000;

   logic        clock = 1'b0;
   logic        reset;
   logic        push;
   logic        full;
   req_type     req_data;
   logic        pop;
   logic        empty;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [11:0] csr_wdata;

   int fail_count;
   int pending_count;
   int checked_count;
   int trigger_count;

   int   sent;
   int   settings;
   int   idle_cycles;
   logic gapless;
   logic hold_req;

   always #10 clock = ~clock;

   ir_proximity_ambient_cancel_sequencer_core dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .pop       (pop),
      .empty     (empty),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ipac_readout_check u_check (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .full          (full),
      .req_data      (req_data),
      .pop           (pop),
      .empty         (empty),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .trigger_count (trigger_count)
   );

   // watchdog: too long without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("ir_proximity_ambient_cancel_sequencer_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [11:0] pick_level();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll == 0) return 12'd0;
      if (roll == 1) return 12'd4095;
      if (roll < 5) return 12'($urandom_range(0, 63));
      return 12'($urandom_range(0, 4095));
   endfunction

   function automatic req_type make_req(op_type op, int ch, int smp, int rk);
      req_type it;
      it.mode = op;
      it.channel = 3'(ch);
      it.sample = 12'(smp);
      it.read_kind = 2'(rk);
      return it;
   endfunction

   // receiving side: random gaps, plus one long hold-off on request
   initial begin
      int gap;
      pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_req) begin
            pop <= 1'b0;
            hold_req <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = gapless ? 0 : pick_gap();
            if (gap > 0) begin
               pop <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
      end
   end

   task automatic send_item(req_type it);
      int gap;
      push <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (full);
      sent++;
      gap = gapless ? 0 : pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // wait until every result is back, then let the pipeline empty out
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      csr_index_type idx;
      logic [11:0]   val;
      csr_valid <= 1'b1;
      for (int k = 0; k < 5; k++) begin
         idx = csr_index_type'(k);
         case (idx)
            CSR_ENABLE:       val = {11'd0, c.enable};
            CSR_SENSE_MODE:   val = {10'd0, c.sensing_mode};
            CSR_AMB_OFFSET:   val = c.ambient_offset;
            CSR_REFL_OFFSET:  val = c.reflection_offset;
            default:          val = c.noise_offset;
         endcase
         csr_index <= idx;
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      settings++;
   endtask

   function automatic cfg_type make_setting(logic en, sense_type md, int amb, int refl,
                                            int nse);
      cfg_type c;
      c.enable = en;
      c.sensing_mode = md;
      c.ambient_offset = 12'(amb);
      c.reflection_offset = 12'(refl);
      c.noise_offset = 12'(nse);
      return c;
   endfunction

   // capture sweep over the channels, occasionally broken up
   task automatic send_sweep();
      int roll;
      for (int ch = 0; ch < 8; ch++) begin
         roll = $urandom_range(0, 99);
         if (ch == 7 || roll >= 12) send_item(make_req(OP_SAMPLE, ch, pick_level(), 0));
         if (roll < 4) send_item(make_req(OP_TICK, 0, 0, 0));
      end
   endtask

   task automatic send_reads(int n);
      for (int k = 0; k < n; k++)
         send_item(make_req(OP_READ, $urandom_range(0, 7), $urandom_range(0, 4095),
                            ($urandom_range(0, 9) == 0) ? 3 : $urandom_range(0, 2)));
   endtask

   task automatic send_burst();
      int roll;
      int n;
      req_type it;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         // well-formed measurement cycle with random content
         send_item(make_req(OP_TICK, 0, 0, 0));
         send_sweep();
         send_item(make_req(OP_TICK, 0, 0, 0));
         send_item(make_req(OP_TICK, 0, 0, 0));
         send_sweep();
         send_item(make_req(OP_TICK, 0, 0, 0));
         send_reads($urandom_range(1, 3));
      end else if (roll < 70) begin
         n = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
         repeat (n) send_item(make_req(OP_TICK, $urandom_range(0, 7), 0, 0));
      end else if (roll < 85) begin
         send_reads($urandom_range(1, 4));
      end else if (roll < 93) begin
         send_sweep();
      end else begin
         repeat ($urandom_range(1, 4)) begin
            it = req_type'($urandom_range(0, (1 << $bits(req_type)) - 1));
            send_item(it);
         end
      end
   endtask

   initial begin
      cfg_type c;
      int      phase_end;
      int      phase_idx;
      reset     <= 1'b1;
      push      <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      gapless   <= 1'b0;
      hold_req  <= 1'b0;
      sent = 0;
      settings = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: ticks and samples do nothing, reads answer zeros
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_SAMPLE, 7, 4095, 0));
      send_item(make_req(OP_READ, 0, 0, RD_AMBIENT));
      send_item(make_req(OP_READ, 5, 0, RD_NOISE));
      send_item(make_req(OP_NONE, 7, 4095, 3));
      settle();

      // pulse schedule with zero offsets and extreme samples
      write_config(make_setting(1'b1, MODE_PULSE, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_SAMPLE, 0, 4095, 0));
      send_item(make_req(OP_SAMPLE, 7, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_SAMPLE, 0, 0, 0));
      send_item(make_req(OP_SAMPLE, 7, 4095, 0));
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_READ, 0, 0, RD_AMBIENT));
      send_item(make_req(OP_READ, 0, 0, RD_REFLECTION));
      send_item(make_req(OP_READ, 0, 0, RD_NOISE));
      send_item(make_req(OP_READ, 7, 0, RD_REFLECTION));
      send_item(make_req(OP_READ, 7, 0, RD_NOISE));
      send_item(make_req(OP_READ, 7, 0, 3));
      settle();

      // largest offsets, then a falling enable edge that clears the stores
      write_config(make_setting(1'b1, MODE_EMIT, 4095, 4095, 4095));
      send_item(make_req(OP_READ, 7, 0, RD_AMBIENT));
      settle();
      write_config(make_setting(1'b0, MODE_EMIT, 4095, 4095, 4095));
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_READ, 7, 0, RD_NOISE));
      settle();

      // rising edge in emit mode lights the emitter
      write_config(make_setting(1'b1, MODE_EMIT, 30, 5, 15));
      send_item(make_req(OP_TICK, 0, 0, 0));
      send_item(make_req(OP_SAMPLE, 3, 100, 0));
      send_item(make_req(OP_TICK, 0, 0, 0));
      settle();

      // noise mode: capture closes without touching the emitter, tick only advances
      write_config(make_setting(1'b1, MODE_NOISE, 30, 5, 15));
      send_item(make_req(OP_SAMPLE, 7, 2048, 0));
      send_item(make_req(OP_TICK, 0, 0, 0));
      settle();

      phase_idx = 0;
      while (sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
         c = make_setting($urandom_range(0, 99) < 85, sense_type'($urandom_range(0, 3)),
                          pick_level(), pick_level(), pick_level());
         // restart through a disabled spell so the phase starts from zero
         if (c.enable && $urandom_range(0, 1) == 1) begin
            c.enable = 1'b0;
            write_config(c);
            repeat ($urandom_range(1, 3)) send_reads(1);
            settle();
            c.enable = 1'b1;
         end
         write_config(c);
         if (phase_idx == 2) begin
            // receiver holds off while the sender keeps pushing
            gapless <= 1'b1;
            hold_req <= 1'b1;
         end else begin
            gapless <= ($urandom_range(0, 4) == 0);
         end
         phase_end = sent + $urandom_range(25, 60);
         while (sent < phase_end) send_burst();
         settle();
         phase_idx++;
      end

      $display("covered %0d items under %0d register settings, %0d results compared",
               sent, settings, checked_count);
      $display("%0d completed measurement cycles reported", trigger_count);
      if (fail_count == 0) begin
         $display("ir_proximity_ambient_cancel_sequencer_core test passed");
      end else begin
         $display("ir_proximity_ambient_cancel_sequencer_core test failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/ipac_pkg.sv
sv/ipac_queue.sv
sv/ipac_front.sv
sv/ipac_back.sv
sv/ir_proximity_ambient_cancel_sequencer_core.sv
tb/ipac_readout_check.sv
tb/tb_ir_proximity_ambient_cancel_sequencer_core.sv
